[hdl/dks_pkg.sv]
package dks_pkg;

    localparam int KEY_W   = 64;
    localparam int CD_W    = 56;
    localparam int HALF_W  = 28;
    localparam int SUB_W   = 48;
    localparam int ROUNDS  = 16;
    localparam int ROUND_W = 4;
    localparam int SLOT_W  = 2;

    typedef logic [CD_W-1:0]    t_cd;
    typedef logic [HALF_W-1:0]  t_half;
    typedef logic [SUB_W-1:0]   t_subkey;
    typedef logic [ROUND_W-1:0] t_round;
    typedef logic [SLOT_W-1:0]  t_slot;

    // one round held in a cell of the chain
    typedef struct packed {
        t_cd    cd;
        t_round round;
        t_slot  slot;
        logic   last;
    } t_entry;

    // published tables, bit 1 = msb
    localparam int PC1_TAB [CD_W] = '{
        57, 49, 41, 33, 25, 17,  9,
         1, 58, 50, 42, 34, 26, 18,
        10,  2, 59, 51, 43, 35, 27,
        19, 11,  3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,
         7, 62, 54, 46, 38, 30, 22,
        14,  6, 61, 53, 45, 37, 29,
        21, 13,  5, 28, 20, 12,  4
    };

    localparam int PC2_TAB [SUB_W] = '{
        14, 17, 11, 24,  1,  5,
         3, 28, 15,  6, 21, 10,
        23, 19, 12,  4, 26,  8,
        16,  7, 27, 20, 13,  2,
        41, 52, 31, 37, 47, 55,
        30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53,
        46, 42, 50, 36, 29, 32
    };

    function automatic t_cd pc1(input logic [KEY_W-1:0] key);
        t_cd r;
        r = '0;
        for (int i = 0; i < CD_W; i++) begin
            r[CD_W-1-i] = key[KEY_W-PC1_TAB[i]];
        end
        return r;
    endfunction

    function automatic t_subkey pc2(input t_cd cd);
        t_subkey r;
        r = '0;
        for (int i = 0; i < SUB_W; i++) begin
            r[SUB_W-1-i] = cd[CD_W-PC2_TAB[i]];
        end
        return r;
    endfunction

    function automatic t_half rotl_half(input t_half v, input logic dbl);
        t_half r;
        if (dbl) begin
            r = {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]};
        end else begin
            r = {v[HALF_W-2:0], v[HALF_W-1]};
        end
        return r;
    endfunction

    // rounds 1, 2, 9 and 16 shift by one, the rest by two
    function automatic logic round_dbl(input int k);
        return !(k == 0 || k == 1 || k == 8 || k == ROUNDS-1);
    endfunction

endpackage

[hdl/dks_cell.sv]
module dks_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_shift,
    input  logic           i_dbl,
    input  dks_pkg::t_cd   i_seed,
    input  dks_pkg::t_round i_round,
    input  logic           i_last,
    input  dks_pkg::t_slot i_slot,
    input  logic           i_next_valid,
    input  dks_pkg::t_entry i_next_entry,
    output dks_pkg::t_cd   o_seed,
    output logic           o_valid,
    output dks_pkg::t_entry o_entry
);
    import dks_pkg::*;

    logic   r_valid, n_valid;
    t_entry r_entry, n_entry;

    // this round's halves, handed on to the next cell for its load
    assign o_seed = {rotl_half(i_seed[CD_W-1:HALF_W], i_dbl),
                     rotl_half(i_seed[HALF_W-1:0], i_dbl)};

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_load) begin
            n_valid       = 1'b1;
            n_entry.cd    = o_seed;
            n_entry.round = i_round;
            n_entry.slot  = i_slot;
            n_entry.last  = i_last;
        end else if (i_shift) begin
            n_valid = i_next_valid;
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;

endmodule

[hdl/des_key_schedule_top.sv]
// channel  direction  handshake                    payload
// key      in         i_key_valid / o_key_ready    i_key_in, i_key_slot
// subkey   out        o_sub_valid / i_sub_ready    o_subkey, o_round_index, o_slot_out, o_last
//
// A key loads all 16 cells of the round chain at once; the chain then moves one
// round per cycle toward the head cell, which drives the outputs, unless the sink
// stalls. The single output port takes one subkey per cycle while the sink is
// ready. The next key is taken as the last subkey leaves.
// Synchronous active-low reset empties the chain. A stalled sink freezes it.
module des_key_schedule_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_key_valid,
    output logic                       o_key_ready,
    input  logic [dks_pkg::KEY_W-1:0]  i_key_in,
    input  dks_pkg::t_slot             i_key_slot,
    output logic                       o_sub_valid,
    input  logic                       i_sub_ready,
    output dks_pkg::t_subkey           o_subkey,
    output dks_pkg::t_round            o_round_index,
    output dks_pkg::t_slot             o_slot_out,
    output logic                       o_last
);
    import dks_pkg::*;

    logic   load, shift;
    t_cd    seed    [ROUNDS+1];
    logic   valid   [ROUNDS+1];
    t_entry entry   [ROUNDS+1];

    assign seed[0]       = pc1(i_key_in);
    assign valid[ROUNDS] = 1'b0;
    assign entry[ROUNDS] = '0;

    // chain fills from the head, so an empty second cell means at most one left
    assign shift       = !valid[0] || i_sub_ready;
    assign o_key_ready = !valid[1] && shift;
    assign load        = i_key_valid && o_key_ready;

    for (genvar k = 0; k < ROUNDS; k++) begin : g_cell
        dks_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (load),
            .i_shift      (shift),
            .i_dbl        (round_dbl(k)),
            .i_seed       (seed[k]),
            .i_round      (ROUND_W'(k)),
            .i_last       (k == ROUNDS-1),
            .i_slot       (i_key_slot),
            .i_next_valid (valid[k+1]),
            .i_next_entry (entry[k+1]),
            .o_seed       (seed[k+1]),
            .o_valid      (valid[k]),
            .o_entry      (entry[k])
        );
    end

    assign o_sub_valid   = valid[0];
    assign o_subkey      = pc2(entry[0].cd);
    assign o_round_index = entry[0].round;
    assign o_slot_out    = entry[0].slot;
    assign o_last        = entry[0].last;

endmodule

[tb/tb.sv]
module tb;
    import dks_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_LIMIT    = 4000;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_KEYS   = 200;
    localparam int MAX_REPORTS   = 40;
    localparam int N_DIRECTED    = 16;

    // bit r set: round r rotates by one, otherwise by two
    localparam logic [ROUNDS-1:0] SINGLE_SHIFT_ROUNDS = 16'h8103;

    // permuted choice tables, 1-based positions counted from the msb
    localparam int PC1_MAP [CD_W] = '{
        57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
        10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
        14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
    };
    localparam int PC2_MAP [SUB_W] = '{
        14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
        23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
    };

    // extremes, alternating bits, parity-only patterns, weak and semi-weak keys
    localparam logic [KEY_W-1:0] DIRECTED_KEYS [N_DIRECTED] = '{
        64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF,
        64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555,
        64'h133457799BBCDFF1, 64'h0101010101010101,
        64'hFEFEFEFEFEFEFEFE, 64'h1F1F1F1F0E0E0E0E,
        64'hE0E0E0E0F1F1F1F1, 64'h01FE01FE01FE01FE,
        64'h8000000000000000, 64'h0000000000000001,
        64'h7F7F7F7F7F7F7F7F, 64'h8080808080808080,
        64'h0123456789ABCDEF, 64'hFFFFFFF000000000
    };

    typedef struct {
        t_subkey subkey;
        t_round  rnd;
        t_slot   slot;
        logic    last_flag;
    } round_key_t;

    class subkey_board;
        round_key_t subkeys_due[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return subkeys_due.size();
        endfunction

        task report_mismatch(input string what);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("mismatch at %0t: %s", $time, what);
            end
        endtask

        function t_cd choose1(input logic [KEY_W-1:0] key);
            t_cd r;
            r = '0;
            for (int i = 0; i < CD_W; i++) begin
                r = {r[CD_W-2:0], key[KEY_W-PC1_MAP[i]]};
            end
            return r;
        endfunction

        function t_subkey choose2(input t_cd cd);
            t_subkey r;
            r = '0;
            for (int i = 0; i < SUB_W; i++) begin
                r = {r[SUB_W-2:0], cd[CD_W-PC2_MAP[i]]};
            end
            return r;
        endfunction

        function t_half rot_half(input t_half h, input int amt);
            return t_half'((h << amt) | (h >> (HALF_W - amt)));
        endfunction

        // expand one key into its sixteen round subkeys
        function void note_key(input logic [KEY_W-1:0] key, input t_slot slot);
            t_cd        cd;
            t_half      c;
            t_half      d;
            int         amt;
            round_key_t e;
            cd = choose1(key);
            c  = cd[CD_W-1:HALF_W];
            d  = cd[HALF_W-1:0];
            for (int r = 0; r < ROUNDS; r++) begin
                amt = SINGLE_SHIFT_ROUNDS[r] ? 1 : 2;
                c = rot_half(c, amt);
                d = rot_half(d, amt);
                e.subkey    = choose2({c, d});
                e.rnd       = t_round'(r);
                e.slot      = slot;
                e.last_flag = (r == ROUNDS - 1);
                subkeys_due.push_back(e);
            end
        endfunction

        task check_subkey(input t_subkey sk, input t_round rnd, input t_slot slot,
                          input logic last_flag);
            round_key_t want;
            if (subkeys_due.size() == 0) begin
                report_mismatch($sformatf("subkey %h round %0d with none expected", sk, rnd));
                return;
            end
            want = subkeys_due.pop_front();
            if (sk !== want.subkey)
                report_mismatch($sformatf("round %0d subkey %h, want %h",
                                          want.rnd, sk, want.subkey));
            if (rnd !== want.rnd)
                report_mismatch($sformatf("round index %0d, want %0d", rnd, want.rnd));
            if (slot !== want.slot)
                report_mismatch($sformatf("round %0d slot %0d, want %0d",
                                          want.rnd, slot, want.slot));
            if (last_flag !== want.last_flag)
                report_mismatch($sformatf("round %0d last %b, want %b",
                                          want.rnd, last_flag, want.last_flag));
        endtask
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             key_valid = 1'b0;
    logic             key_ready;
    logic [KEY_W-1:0] key_in    = '0;
    t_slot            key_slot  = '0;
    logic             sub_valid;
    logic             sub_ready = 1'b0;
    t_subkey          subkey;
    t_round           round_index;
    t_slot            slot_out;
    logic             last_flag;

    subkey_board sb = new();
    int keys_sent   = 0;
    int idle_cycles = 0;
    bit long_hold_done = 0;

    des_key_schedule_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_key_valid   (key_valid),
        .o_key_ready   (key_ready),
        .i_key_in      (key_in),
        .i_key_slot    (key_slot),
        .o_sub_valid   (sub_valid),
        .i_sub_ready   (sub_ready),
        .o_subkey      (subkey),
        .o_round_index (round_index),
        .o_slot_out    (slot_out),
        .o_last        (last_flag)
    );

    always #HALF_PERIOD clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // holds valid across back-to-back transactions; drops it only for a gap
    task automatic send_key(input logic [KEY_W-1:0] k, input t_slot s, input bit no_gap);
        int gap;
        key_valid <= 1'b1;
        key_in    <= k;
        key_slot  <= s;
        @(posedge clk);
        while (!key_ready) @(posedge clk);
        sb.note_key(k, s);
        keys_sent++;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            key_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial begin : source
        logic [KEY_W-1:0] k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_key(DIRECTED_KEYS[i], t_slot'(i % 4), 1'b0);
        end
        for (int n = 0; n < RANDOM_KEYS; n++) begin
            k = {$urandom, $urandom};
            // some sparse keys: a single set bit or a single clear bit
            if ($urandom_range(0, 9) == 0) begin
                k = 64'd1 << $urandom_range(0, KEY_W - 1);
                if ($urandom_range(0, 1) == 1) k = ~k;
            end
            send_key(k, t_slot'($urandom_range(0, 3)), n >= 100 && n < 140);
        end
        key_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0) begin
            $display("PASS des_key_schedule_top");
        end else begin
            $display("FAIL des_key_schedule_top");
        end
        $finish;
    end

    initial begin : sink
        int hold;
        @(posedge clk);
        forever begin
            if (!long_hold_done && keys_sent >= 40) begin
                // long back-pressure: chain fills and the key channel stalls
                sub_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1;
            end else if (keys_sent >= 120 && keys_sent < 150) begin
                sub_ready <= 1'b1;
                @(posedge clk);
            end else begin
                sub_ready <= 1'b1;
                @(posedge clk);
                hold = pick_gap();
                if (hold > 0) begin
                    sub_ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && sub_valid && sub_ready) begin
            sb.check_subkey(subkey, round_index, slot_out, last_flag);
        end
    end

    always @(posedge clk) begin
        if ((key_valid && key_ready) || (sub_valid && sub_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL des_key_schedule_top");
            $finish;
        end
    end

endmodule
